@@ rtl/median_filter_3x3_unit_defines.svh @@
// assertion macros for the 3x3 median filter
`ifndef MEDIAN_FILTER_3X3_UNIT_DEFINES_SVH
`define MEDIAN_FILTER_3X3_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define MF3_ASSERT_CLK(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define MF3_ASSERT(name, prop, msg) \
  `MF3_ASSERT_CLK(name, clk_i, rst_ni, prop, msg)

`else

`define MF3_ASSERT_CLK(name, clk, rst_n, prop, msg)

`define MF3_ASSERT(name, prop, msg)

`endif

`endif

@@ rtl/mf3_pkg.sv @@
// shared types and constants of the 3x3 median filter
package mf3_pkg;

  localparam int PIX_W      = 8;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 12;
  localparam int ROW_W      = 13;
  localparam int WIN_ROWS   = 3;
  localparam int WIN_SIZE   = 9;
  localparam int MID_DEPTH  = 4;
  localparam int MID_CNT_W  = $clog2(MID_DEPTH + 1);
  localparam int OUT_DEPTH  = 4;
  localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 12'd480;

  localparam logic REG_IDX_WIDTH  = 1'b0;
  localparam logic REG_IDX_HEIGHT = 1'b1;

  typedef struct packed {
    logic emit;
    logic interior;
    logic last;
  } item_flags_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [PIX_W-1:0] above;
    logic [PIX_W-1:0] two_above;
    item_flags_t      flags;
  } mid_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
  } out_item_t;

endpackage

@@ rtl/mf3_ram.sv @@
// generic simple dual-port ram with registered read
module mf3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/mf3_fifo.sv @@
// small register fifo with occupancy count
module mf3_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           wdata_i,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           rdata_o,
  output logic                       empty_o,
  output logic                       full_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[rptr_q];
  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign count_o = count_q;

endmodule

@@ rtl/mf3_front.sv @@
// front end: raster counters, item classification and line stores
module mf3_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [mf3_pkg::WIDTH_W-1:0]    image_width_i,
  input  logic [mf3_pkg::HEIGHT_W-1:0]   image_height_i,
  input  logic                           restart_i,
  input  logic                           push_i,
  output logic                           full_o,
  input  logic [mf3_pkg::PIX_W-1:0]      pixel_in_i,
  input  logic                           drain_i,
  input  logic [mf3_pkg::MID_CNT_W-1:0]  mid_count_i,
  output logic                           mid_push_o,
  output mf3_pkg::mid_item_t             mid_item_o
);

  import mf3_pkg::*;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int LINE_W = 2 * PIX_W;

  logic [COL_W-1:0]    col_q, col_d, w_last;
  logic [ROW_W-1:0]    row_q, row_d, row_end;
  logic [HEIGHT_W-1:0] h_last;
  logic                accept, in_frame, take;
  item_flags_t         flags;
  logic [PIX_W-1:0]    pix;

  logic                s1_valid_q;
  logic [COL_W-1:0]    s1_addr_q;
  logic [PIX_W-1:0]    s1_pix_q;
  item_flags_t         s1_flags_q;
  logic                fwd_sel_q, fwd_sel_d;
  logic [LINE_W-1:0]   fwd_word_q;
  logic [LINE_W-1:0]   line_rd, line_cur, line_wr;
  logic [MID_CNT_W:0]  slots_used;

  // clamped frame geometry
  always_comb begin
    if (image_width_i == '0) begin
      w_last = '0;
    end else if (32'(image_width_i) > MAX_WIDTH) begin
      w_last = COL_W'(MAX_WIDTH - 1);
    end else begin
      w_last = COL_W'(32'(image_width_i) - 32'd1);
    end
  end

  assign h_last  = (image_height_i == '0) ? '0 : image_height_i - HEIGHT_W'(1);
  assign row_end = {1'b0, h_last} + ROW_W'(2);

  assign slots_used = {1'b0, mid_count_i} + (MID_CNT_W + 1)'(s1_valid_q);
  assign full_o     = (slots_used >= (MID_CNT_W + 1)'(MID_DEPTH));

  assign accept   = push_i && !full_o;
  assign in_frame = (row_q <= {1'b0, h_last});
  assign take     = accept && !(in_frame && drain_i);
  assign pix      = in_frame ? pixel_in_i : '0;

  // classify the item by the raster position it completes
  always_comb begin
    flags.emit     = (row_q >= ROW_W'(2)) || ((row_q == ROW_W'(1)) && (col_q != '0));
    flags.interior = (col_q >= COL_W'(2)) && (row_q >= ROW_W'(2)) && in_frame;
    flags.last     = (col_q == '0) && (row_q == row_end);
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (restart_i) begin
      col_d = '0;
      row_d = '0;
    end else if (take) begin
      if (flags.last) begin
        col_d = '0;
        row_d = '0;
      end else if (col_q == w_last) begin
        col_d = '0;
        row_d = row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  // line word: above in the upper byte, two rows above in the lower byte
  assign line_cur  = fwd_sel_q ? fwd_word_q : line_rd;
  assign line_wr   = {s1_pix_q, line_cur[LINE_W-1:PIX_W]};
  assign fwd_sel_d = take && s1_valid_q && (s1_addr_q == col_q);

  mf3_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_addr_q),
    .wdata_i (line_wr),
    .re_i    (take),
    .raddr_i (col_q),
    .rdata_o (line_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      fwd_sel_q  <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= take;
      fwd_sel_q  <= fwd_sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_addr_q  <= col_q;
      s1_pix_q   <= pix;
      s1_flags_q <= flags;
      fwd_word_q <= line_wr;
    end
  end

  assign mid_push_o           = s1_valid_q;
  assign mid_item_o.pix       = s1_pix_q;
  assign mid_item_o.above     = line_cur[LINE_W-1:PIX_W];
  assign mid_item_o.two_above = line_cur[PIX_W-1:0];
  assign mid_item_o.flags     = s1_flags_q;

endmodule

@@ rtl/mf3_back.sv @@
// back end: 3x3 window, pipelined median and result fifo
module mf3_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      mid_empty_i,
  input  mf3_pkg::mid_item_t        mid_item_i,
  output logic                      mid_pop_o,
  input  logic                      pop_i,
  output logic                      empty_o,
  output logic [mf3_pkg::PIX_W-1:0] pixel_out_o,
  output logic                      frame_last_o
);

  import mf3_pkg::*;

  function automatic logic [PIX_W-1:0] min2(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [PIX_W-1:0] max2(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
    return (a < b) ? b : a;
  endfunction

  function automatic logic [PIX_W-1:0] med3(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b,
                                             logic [PIX_W-1:0] c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  logic [PIX_W-1:0] win_q [WIN_SIZE];
  logic [PIX_W-1:0] win_d [WIN_SIZE];
  logic             a_valid_q, a_int_q, a_last_q;

  logic [PIX_W-1:0] col_lo [WIN_ROWS];
  logic [PIX_W-1:0] col_mid [WIN_ROWS];
  logic [PIX_W-1:0] col_hi [WIN_ROWS];
  logic [PIX_W-1:0] b_lo_q [WIN_ROWS];
  logic [PIX_W-1:0] b_mid_q [WIN_ROWS];
  logic [PIX_W-1:0] b_hi_q [WIN_ROWS];
  logic [PIX_W-1:0] b_ctr_q;
  logic             b_valid_q, b_int_q, b_last_q;

  logic [PIX_W-1:0] lo_max, mid_med, hi_min, median;
  out_item_t        out_item, out_head;
  logic [OUT_CNT_W-1:0] out_count;
  logic [OUT_CNT_W:0]   out_used;

  assign out_used  = {1'b0, out_count} + (OUT_CNT_W + 1)'(a_valid_q)
                   + (OUT_CNT_W + 1)'(b_valid_q);
  assign mid_pop_o = !mid_empty_i && (out_used < (OUT_CNT_W + 1)'(OUT_DEPTH));

  // shift in one column: oldest column at the low indexes
  always_comb begin
    for (int i = 0; i < WIN_SIZE - WIN_ROWS; i++) begin
      win_d[i] = win_q[i + WIN_ROWS];
    end
    win_d[WIN_SIZE-3] = mid_item_i.two_above;
    win_d[WIN_SIZE-2] = mid_item_i.above;
    win_d[WIN_SIZE-1] = mid_item_i.pix;
  end

  always_ff @(posedge clk_i) begin
    if (mid_pop_o) begin
      win_q    <= win_d;
      a_int_q  <= mid_item_i.flags.interior;
      a_last_q <= mid_item_i.flags.last;
    end
  end

  // sort each column
  always_comb begin
    for (int k = 0; k < WIN_ROWS; k++) begin
      col_lo[k]  = min2(min2(win_q[k*WIN_ROWS], win_q[k*WIN_ROWS+1]), win_q[k*WIN_ROWS+2]);
      col_hi[k]  = max2(max2(win_q[k*WIN_ROWS], win_q[k*WIN_ROWS+1]), win_q[k*WIN_ROWS+2]);
      col_mid[k] = med3(win_q[k*WIN_ROWS], win_q[k*WIN_ROWS+1], win_q[k*WIN_ROWS+2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_valid_q) begin
      b_lo_q   <= col_lo;
      b_mid_q  <= col_mid;
      b_hi_q   <= col_hi;
      b_ctr_q  <= win_q[WIN_SIZE/2];
      b_int_q  <= a_int_q;
      b_last_q <= a_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= mid_pop_o && mid_item_i.flags.emit;
      b_valid_q <= a_valid_q;
    end
  end

  assign lo_max  = max2(max2(b_lo_q[0], b_lo_q[1]), b_lo_q[2]);
  assign hi_min  = min2(min2(b_hi_q[0], b_hi_q[1]), b_hi_q[2]);
  assign mid_med = med3(b_mid_q[0], b_mid_q[1], b_mid_q[2]);
  assign median  = med3(lo_max, mid_med, hi_min);

  assign out_item.pixel = b_int_q ? median : b_ctr_q;
  assign out_item.last  = b_last_q;

  mf3_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (b_valid_q),
    .wdata_i (out_item),
    .pop_i   (pop_i),
    .rdata_o (out_head),
    .empty_o (empty_o),
    .full_o  (),
    .count_o (out_count)
  );

  assign pixel_out_o  = out_head.pixel;
  assign frame_last_o = out_head.last;

endmodule

@@ rtl/median_filter_3x3_unit.sv @@
// top level of the streaming 3x3 median filter with apb register port
// the result of pixel p is formed from the window completed by item p + width + 1
// throughput: one item per cycle while full is low, set by the single line ram read port
// reset: width 640, height 480, raster counters zero; line ram is not cleared
`include "median_filter_3x3_unit_defines.svh"

module median_filter_3x3_unit #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mf3_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [mf3_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [mf3_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  input  logic                             push,
  output logic                             full,
  input  logic [mf3_pkg::PIX_W-1:0]        pixel_in_i,
  input  logic                             drain_i,
  output logic                             empty,
  input  logic                             pop,
  output logic [mf3_pkg::PIX_W-1:0]        pixel_out_o,
  output logic                             frame_last_o
);

  import mf3_pkg::*;

  logic [WIDTH_W-1:0]  image_width_q, image_width_d;
  logic [HEIGHT_W-1:0] image_height_q, image_height_d;
  logic                cfg_wr;

  logic                mid_push, mid_pop, mid_empty, mid_full;
  mid_item_t           mid_wr_item, mid_rd_item;
  logic [MID_CNT_W-1:0] mid_count;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    image_width_d  = image_width_q;
    image_height_d = image_height_q;
    if (cfg_wr) begin
      case (paddr[2])
        REG_IDX_WIDTH:  image_width_d  = pwdata[WIDTH_W-1:0];
        REG_IDX_HEIGHT: image_height_d = pwdata[HEIGHT_W-1:0];
        default: begin
          image_width_d  = image_width_q;
          image_height_d = image_height_q;
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_IDX_WIDTH:  prdata = APB_DATA_W'(image_width_q);
      REG_IDX_HEIGHT: prdata = APB_DATA_W'(image_height_q);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= WIDTH_RESET;
      image_height_q <= HEIGHT_RESET;
    end else begin
      image_width_q  <= image_width_d;
      image_height_q <= image_height_d;
    end
  end

  mf3_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .image_width_i  (image_width_q),
    .image_height_i (image_height_q),
    .restart_i      (cfg_wr),
    .push_i         (push),
    .full_o         (full),
    .pixel_in_i     (pixel_in_i),
    .drain_i        (drain_i),
    .mid_count_i    (mid_count),
    .mid_push_o     (mid_push),
    .mid_item_o     (mid_wr_item)
  );

  mf3_fifo #(
    .WIDTH ($bits(mid_item_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .wdata_i (mid_wr_item),
    .pop_i   (mid_pop),
    .rdata_o (mid_rd_item),
    .empty_o (mid_empty),
    .full_o  (mid_full),
    .count_o (mid_count)
  );

  mf3_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mid_empty_i  (mid_empty),
    .mid_item_i   (mid_rd_item),
    .mid_pop_o    (mid_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .pixel_out_o  (pixel_out_o),
    .frame_last_o (frame_last_o)
  );

  `MF3_ASSERT(a_mid_no_overflow, mid_push |-> !mid_full, "mid queue written while full")
  `MF3_ASSERT(a_mid_no_underflow, mid_pop |-> !mid_empty, "mid queue read while empty")
  `MF3_ASSERT(a_width_write, (cfg_wr && !paddr[2]) |=> (image_width_q == $past(pwdata[10:0])), "width register write lost")

endmodule

@@ tb/median_filter_3x3_unit_test.sv @@
// self-checking testbench of the streaming 3x3 median filter with its apb register port
module median_filter_3x3_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mf3_pkg::*;

  localparam int LINE_DEPTH    = 1024;
  localparam int LIMIT_CYCLES  = 1000000;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_ITEMS  = 400;
  localparam int DIR_ROWS      = 16;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             drn;
    logic             typed;
    logic [PIX_W-1:0] exp_pix;
    logic             exp_last;
  } dir_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  push;
  logic                  full;
  logic [PIX_W-1:0]      pixel_in_i;
  logic                  drain_i;
  logic                  empty;
  logic                  pop;
  logic [PIX_W-1:0]      pixel_out_o;
  logic                  frame_last_o;

  // predictor state
  logic [WIDTH_W-1:0]  width_reg = WIDTH_RESET;
  logic [HEIGHT_W-1:0] height_reg = HEIGHT_RESET;
  logic [PIX_W-1:0]    line_above [LINE_DEPTH];
  logic [PIX_W-1:0]    line_two_above [LINE_DEPTH];
  logic [PIX_W-1:0]    nbhd [WIN_SIZE];
  int unsigned         next_col = 0;
  int unsigned         next_row = 0;
  int unsigned         next_out = 0;

  out_item_t   pending_pixels [$];
  bit          no_idle = 1'b0;
  int          fail_count = 0;
  int unsigned beats_taken = 0;
  int unsigned beats_ignored = 0;
  int unsigned results_seen = 0;
  int unsigned frames_closed = 0;
  int unsigned reg_writes = 0;
  int unsigned holdoffs = 0;
  int unsigned cycle_count = 0;

  // 3x3 frame: corners and edges pass, the center takes the median of all nine
  dir_row_t dir_table [DIR_ROWS] = '{
    '{8'd0,   1'b1, 1'b0, 8'd0,   1'b0},
    '{8'd255, 1'b0, 1'b0, 8'd0,   1'b0},
    '{8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
    '{8'd255, 1'b0, 1'b0, 8'd0,   1'b0},
    '{8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
    '{8'd77,  1'b1, 1'b0, 8'd0,   1'b0},
    '{8'd7,   1'b0, 1'b1, 8'd255, 1'b0},
    '{8'd255, 1'b0, 1'b1, 8'd0,   1'b0},
    '{8'd0,   1'b0, 1'b1, 8'd255, 1'b0},
    '{8'd255, 1'b0, 1'b1, 8'd0,   1'b0},
    '{8'd0,   1'b0, 1'b1, 8'd7,   1'b0},
    '{8'd123, 1'b0, 1'b1, 8'd255, 1'b0},
    '{8'd0,   1'b1, 1'b1, 8'd0,   1'b0},
    '{8'd0,   1'b1, 1'b1, 8'd255, 1'b0},
    '{8'd0,   1'b1, 1'b1, 8'd0,   1'b1},
    '{8'd200, 1'b1, 1'b0, 8'd0,   1'b0}
  };

  median_filter_3x3_unit #(
    .MAX_WIDTH(LINE_DEPTH)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .push        (push),
    .full        (full),
    .pixel_in_i  (pixel_in_i),
    .drain_i     (drain_i),
    .empty       (empty),
    .pop         (pop),
    .pixel_out_o (pixel_out_o),
    .frame_last_o(frame_last_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int unsigned eff_width();
    int unsigned w;
    w = width_reg;
    if (w < 1) w = 1;
    if (w > LINE_DEPTH) w = LINE_DEPTH;
    return w;
  endfunction

  function automatic int unsigned eff_height();
    return (height_reg == '0) ? 1 : height_reg;
  endfunction

  function automatic logic [PIX_W-1:0] median_of_nbhd();
    logic [PIX_W-1:0] sorted [WIN_SIZE];
    logic [PIX_W-1:0] key;
    int i;
    int j;
    for (i = 0; i < WIN_SIZE; i++) sorted[i] = nbhd[i];
    for (i = 1; i < WIN_SIZE; i++) begin
      key = sorted[i];
      j = i - 1;
      while (j >= 0 && sorted[j] > key) begin
        sorted[j + 1] = sorted[j];
        j--;
      end
      sorted[j + 1] = key;
    end
    return sorted[WIN_SIZE / 2];
  endfunction

  function automatic void restart_raster();
    next_col = 0;
    next_row = 0;
    next_out = 0;
  endfunction

  function automatic void filter_step(input logic [PIX_W-1:0] pix, input logic drn,
                                      output bit taken, output bit produced,
                                      output out_item_t res);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned pos;
    int unsigned p;
    int unsigned orow;
    int unsigned ocol;
    logic [PIX_W-1:0] v;
    logic [PIX_W-1:0] edge_pix;
    bit in_frame;
    int i;
    w = eff_width();
    h = eff_height();
    in_frame = next_row < h;
    taken = 1'b0;
    produced = 1'b0;
    res = '0;
    if (in_frame && drn) return;
    taken = 1'b1;
    v = in_frame ? pix : '0;
    c = next_col % w;
    edge_pix = line_two_above[w - 1];
    for (i = 0; i < 6; i++) nbhd[i] = nbhd[i + 3];
    nbhd[6] = line_two_above[c];
    nbhd[7] = line_above[c];
    nbhd[8] = v;
    line_two_above[c] = line_above[c];
    line_above[c] = v;
    pos = next_row * w + c;
    next_col = c + 1;
    if (next_col >= w) begin
      next_col = 0;
      next_row++;
    end
    if (pos < w + 1) return;
    p = next_out;
    orow = p / w;
    ocol = p % w;
    if (c == 0) begin
      res.pixel = edge_pix;
    end else if (w >= 3 && h >= 3 && orow >= 1 && orow + 2 <= h &&
                 ocol >= 1 && ocol + 2 <= w) begin
      res.pixel = median_of_nbhd();
    end else begin
      res.pixel = nbhd[4];
    end
    next_out = p + 1;
    res.last = (p + 1 >= h * w);
    if (res.last) restart_raster();
    produced = 1'b1;
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return PIX_W'($urandom_range(100, 103));
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_item(input logic [PIX_W-1:0] pix, input logic drn,
                           input bit typed, input out_item_t typed_res);
    int gap;
    bit ok;
    bit taken;
    bit produced;
    out_item_t res;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    pixel_in_i <= pix;
    drain_i <= drn;
    do begin
      @(negedge clk_i);
      ok = !full;
      @(posedge clk_i);
    end while (!ok);
    filter_step(pix, drn, taken, produced, res);
    if (produced) pending_pixels.push_back(typed ? typed_res : res);
    if (taken) beats_taken++;
    else beats_ignored++;
  endtask

  task automatic settle();
    push <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [APB_DATA_W-1:0] field_mask(input logic idx);
    return (idx == REG_IDX_WIDTH) ? ((32'd1 << WIDTH_W) - 1) : ((32'd1 << HEIGHT_W) - 1);
  endfunction

  task automatic read_reg(input logic idx, input logic [APB_DATA_W-1:0] want);
    logic [APB_DATA_W-1:0] data;
    bit rdy;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= APB_ADDR_W'({idx, 2'b00});
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
      rdy = pready;
      data = prdata;
      @(posedge clk_i);
    end while (!rdy);
    if ((data & field_mask(idx)) != want) begin
      $error("prdata: expected %0d, actual %0d", want, data & field_mask(idx));
      fail_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input int unsigned value);
    logic [APB_DATA_W-1:0] mask;
    bit rdy;
    mask = field_mask(idx);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_ADDR_W'({idx, 2'b00});
    pwdata <= (APB_DATA_W'(value) & mask) | ($urandom() & ~mask);
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
      rdy = pready;
      @(posedge clk_i);
    end while (!rdy);
    if (idx == REG_IDX_WIDTH) width_reg = WIDTH_W'(value);
    else height_reg = HEIGHT_W'(value);
    restart_raster();
    reg_writes++;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    read_reg(idx, APB_DATA_W'(value) & mask);
  endtask

  task automatic send_frame(input bit cut);
    int unsigned w;
    int unsigned npix;
    int unsigned lim;
    int unsigned i;
    w = eff_width();
    npix = w * eff_height();
    if (cut) begin
      lim = npix - 1;
      if (lim > 4 * w + 40) lim = 4 * w + 40;
      npix = $urandom_range(0, lim);
    end
    for (i = 0; i < npix; i++) begin
      if ($urandom_range(0, 29) == 0) send_item(rand_pixel(), 1'b1, 1'b0, '0);
      send_item(rand_pixel(), 1'b0, 1'b0, '0);
    end
    if (cut) return;
    for (i = 0; i <= w; i++) send_item(rand_pixel(), $urandom_range(0, 4) != 0, 1'b0, '0);
    if ($urandom_range(0, 3) == 0) send_item(rand_pixel(), 1'b1, 1'b0, '0);
  endtask

  task automatic run_phase(input bit set_w, input int unsigned w_val, input bit set_h,
                           input int unsigned h_val, input int frames, input bit cut_last);
    int f;
    settle();
    if (set_h && $urandom_range(0, 1) == 1) begin
      write_reg(REG_IDX_HEIGHT, h_val);
      if (set_w) write_reg(REG_IDX_WIDTH, w_val);
    end else begin
      if (set_w) write_reg(REG_IDX_WIDTH, w_val);
      if (set_h) write_reg(REG_IDX_HEIGHT, h_val);
    end
    for (f = 0; f < frames; f++) send_frame(cut_last && f == frames - 1);
  endtask

  task automatic random_phase();
    int unsigned w_val;
    int unsigned h_val;
    bit set_w;
    bit set_h;
    case ($urandom_range(0, 19))
      0: w_val = 0;
      1, 2, 3, 4: w_val = $urandom_range(9, 40);
      default: w_val = $urandom_range(1, 8);
    endcase
    case ($urandom_range(0, 19))
      0: h_val = 0;
      1, 2, 3: h_val = $urandom_range(9, 20);
      default: h_val = $urandom_range(1, 8);
    endcase
    set_w = $urandom_range(0, 2) != 0;
    set_h = !set_w || $urandom_range(0, 1) == 1;
    no_idle = $urandom_range(0, 4) == 0;
    run_phase(set_w, w_val, set_h, h_val, $urandom_range(1, 3), $urandom_range(0, 7) == 0);
  endtask

  initial begin : result_sink
    int stall;
    bit got;
    out_item_t seen;
    out_item_t want;
    pop <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop <= 1'b1;
      do begin
        @(negedge clk_i);
        got = !empty;
        seen.pixel = pixel_out_o;
        seen.last = frame_last_o;
        @(posedge clk_i);
      end while (!got);
      if (pending_pixels.size() == 0) begin
        $error("pixel_out: expected no beat, actual %0d", seen.pixel);
        fail_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (seen.pixel !== want.pixel) begin
          $error("pixel_out: expected %0d, actual %0d", want.pixel, seen.pixel);
          fail_count++;
        end
        if (seen.last !== want.last) begin
          $error("frame_last: expected %0d, actual %0d", want.last, seen.last);
          fail_count++;
        end
      end
      results_seen++;
      if (seen.last === 1'b1) frames_closed++;
      if (results_seen % 700 == 300) begin
        holdoffs++;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    int unsigned taken_before;
    int r;
    out_item_t typed_res;
    for (r = 0; r < LINE_DEPTH; r++) begin
      line_above[r] = '0;
      line_two_above[r] = '0;
    end
    for (r = 0; r < WIN_SIZE; r++) nbhd[r] = '0;
    rst_ni <= 1'b0;
    push <= 1'b0;
    pixel_in_i <= '0;
    drain_i <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    read_reg(REG_IDX_WIDTH, APB_DATA_W'(WIDTH_RESET));
    read_reg(REG_IDX_HEIGHT, APB_DATA_W'(HEIGHT_RESET));

    write_reg(REG_IDX_WIDTH, 3);
    write_reg(REG_IDX_HEIGHT, 3);
    for (r = 0; r < DIR_ROWS; r++) begin
      typed_res.pixel = dir_table[r].exp_pix;
      typed_res.last = dir_table[r].exp_last;
      send_item(dir_table[r].pix, dir_table[r].drn, dir_table[r].typed, typed_res);
    end

    // out-of-range width and height, then the register extremes and small frames
    run_phase(1'b1, 0, 1'b1, 0, 2, 1'b0);
    run_phase(1'b1, 2047, 1'b1, 1, 1, 1'b0);
    run_phase(1'b1, 1, 1'b1, 4095, 1, 1'b1);
    run_phase(1'b1, 2, 1'b1, 2, 1, 1'b1);
    run_phase(1'b1, 3, 1'b0, 0, 1, 1'b0);

    taken_before = beats_taken;
    while (beats_taken - taken_before < RANDOM_ITEMS) random_phase();

    settle();
    $display("covered %0d pixel beats and %0d ignored drains, %0d result beats checked",
             beats_taken, beats_ignored, results_seen);
    $display("across %0d register writes, %0d closed frames and %0d long output stalls",
             reg_writes, frames_closed, holdoffs);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/mf3_pkg.sv
rtl/mf3_ram.sv
rtl/mf3_fifo.sv
rtl/mf3_front.sv
rtl/mf3_back.sv
rtl/median_filter_3x3_unit.sv
tb/median_filter_3x3_unit_test.sv
